// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// ante at one edge requires cons at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/jsof_pkg.sv =====
// ----------------------------------------------------------------------------
// jsof_pkg
// Types and constants of the JPEG start-of-frame header parser.
// ----------------------------------------------------------------------------
package jsof_pkg;

    // Marker words
    localparam logic [15:0] MARK_SOI  = 16'hFFD8;
    localparam logic [15:0] MARK_EOI  = 16'hFFD9;
    localparam logic [15:0] MARK_FILL = 16'hFFFF;
    localparam logic [15:0] MARK_SOF0 = 16'hFFC0;
    localparam logic [15:0] MARK_SOF2 = 16'hFFC2;

    // Component counts
    localparam logic [7:0] NCOMP_RGB  = 8'd3;
    localparam logic [7:0] NCOMP_CMYK = 8'd4;

    // Smallest legal segment length (covers the length word itself)
    localparam logic [15:0] SEG_LEN_MIN = 16'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SOI    = 3'd1,
        ST_END_FILL  = 3'd2,
        ST_BAD_NCOMP = 3'd3,
        ST_EARLY_END = 3'd4,
        ST_SHORT_LEN = 3'd5
    } t_status;

    // Parser phases
    typedef enum logic [3:0] {
        PH_SOI_HI  = 4'd0,
        PH_SOI_LO  = 4'd1,
        PH_MARK_HI = 4'd2,
        PH_MARK_LO = 4'd3,
        PH_LEN_HI  = 4'd4,
        PH_LEN_LO  = 4'd5,
        PH_SKIP    = 4'd6,
        PH_FLEN_HI = 4'd7,
        PH_FLEN_LO = 4'd8,
        PH_PREC    = 4'd9,
        PH_H_HI    = 4'd10,
        PH_H_LO    = 4'd11,
        PH_W_HI    = 4'd12,
        PH_W_LO    = 4'd13,
        PH_NCOMP   = 4'd14,
        PH_DONE    = 4'd15
    } t_phase;

    // One input byte with its flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       end_of_stream;
    } t_in_item;

    // Input stage to parser
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_in_stage;

    // One parse result
    typedef struct packed {
        t_status     status;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        is_cmyk;
    } t_result;

endpackage

// ===== rtl/jsof_in_stage.sv =====
// ----------------------------------------------------------------------------
// jsof_in_stage
// Input register: holds one accepted byte until the parser takes it.
// ----------------------------------------------------------------------------
module jsof_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  jsof_pkg::t_in_item i_item,
    output jsof_pkg::t_in_stage o_stage,
    input  logic               i_take
);
    import jsof_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Free when empty or when the held byte leaves this cycle
    assign o_ready = !r_valid || i_take;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

// ===== rtl/jsof_parser.sv =====
// ----------------------------------------------------------------------------
// jsof_parser
// Marker state machine, one byte per step, with the result register.
// ----------------------------------------------------------------------------
module jsof_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jsof_pkg::t_in_stage i_stage,
    output logic                o_take,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output jsof_pkg::t_result   o_result
);
    import jsof_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_hold,   n_hold;
    logic [15:0] r_skip,   n_skip;
    logic [15:0] r_height, n_height;
    logic [15:0] r_width,  n_width;
    logic        r_res_valid;
    t_result     r_result;

    logic        w_step;
    t_phase      w_phase;
    logic [7:0]  w_data;
    logic [15:0] w_word;
    logic [15:0] w_skip_dec;
    logic        w_fire;
    t_status     w_status;
    logic        w_cmyk;

    // A byte is taken whenever the result register can hold a new result
    assign w_step = i_stage.valid && (!r_res_valid || i_res_ready);
    assign o_take = w_step;

    // A first byte restarts the parse from the start marker
    assign w_phase    = i_stage.item.first_byte ? PH_SOI_HI : r_phase;
    assign w_data     = i_stage.item.data_byte;
    assign w_word     = {r_hold, w_data};
    assign w_skip_dec = r_skip - 16'd1;

    // Next state
    always_comb begin
        n_phase  = r_phase;
        n_hold   = r_hold;
        n_skip   = r_skip;
        n_height = r_height;
        n_width  = r_width;
        if (w_step) begin
            n_phase = w_phase;
            if (w_phase == PH_DONE) begin
                n_phase = PH_DONE;
            end else if (i_stage.item.end_of_stream) begin
                n_phase = PH_DONE;
            end else begin
                unique case (w_phase)
                    PH_SOI_HI: begin
                        n_hold  = w_data;
                        n_phase = PH_SOI_LO;
                    end
                    PH_SOI_LO: begin
                        n_phase = (w_word == MARK_SOI) ? PH_MARK_HI : PH_DONE;
                    end
                    PH_MARK_HI: begin
                        n_hold  = w_data;
                        n_phase = PH_MARK_LO;
                    end
                    PH_MARK_LO: begin
                        priority if (w_word == MARK_SOF0 || w_word == MARK_SOF2) begin
                            n_phase = PH_FLEN_HI;
                        end else if (w_word == MARK_FILL || w_word == MARK_EOI) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI: begin
                        n_hold  = w_data;
                        n_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_skip = w_word - SEG_LEN_MIN;
                        priority if (w_word < SEG_LEN_MIN) begin
                            n_phase = PH_DONE;
                        end else if (w_word == SEG_LEN_MIN) begin
                            n_phase = PH_MARK_HI;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        n_skip = w_skip_dec;
                        if (w_skip_dec == 16'd0) begin
                            n_phase = PH_MARK_HI;
                        end
                    end
                    PH_FLEN_HI: n_phase = PH_FLEN_LO;
                    PH_FLEN_LO: n_phase = PH_PREC;
                    PH_PREC:    n_phase = PH_H_HI;
                    PH_H_HI: begin
                        n_hold  = w_data;
                        n_phase = PH_H_LO;
                    end
                    PH_H_LO: begin
                        n_height = w_word;
                        n_phase  = PH_W_HI;
                    end
                    PH_W_HI: begin
                        n_hold  = w_data;
                        n_phase = PH_W_LO;
                    end
                    PH_W_LO: begin
                        n_width = w_word;
                        n_phase = PH_NCOMP;
                    end
                    PH_NCOMP: n_phase = PH_DONE;
                    default:  n_phase = PH_DONE;
                endcase
            end
        end
    end

    // Result generation
    always_comb begin
        w_fire   = 1'b0;
        w_status = ST_OK;
        w_cmyk   = 1'b0;
        if (w_step && w_phase != PH_DONE) begin
            priority if (i_stage.item.end_of_stream) begin
                w_fire   = 1'b1;
                w_status = ST_EARLY_END;
            end else if (w_phase == PH_SOI_LO && w_word != MARK_SOI) begin
                w_fire   = 1'b1;
                w_status = ST_NO_SOI;
            end else if (w_phase == PH_MARK_LO
                         && (w_word == MARK_FILL || w_word == MARK_EOI)) begin
                w_fire   = 1'b1;
                w_status = ST_END_FILL;
            end else if (w_phase == PH_LEN_LO && w_word < SEG_LEN_MIN) begin
                w_fire   = 1'b1;
                w_status = ST_SHORT_LEN;
            end else if (w_phase == PH_NCOMP) begin
                w_fire = 1'b1;
                priority if (w_data == NCOMP_RGB) begin
                    w_status = ST_OK;
                end else if (w_data == NCOMP_CMYK) begin
                    w_status = ST_OK;
                    w_cmyk   = 1'b1;
                end else begin
                    w_status = ST_BAD_NCOMP;
                end
            end else begin
                w_fire = 1'b0;
            end
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SOI_HI;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Held words, no reset needed
    always_ff @(posedge i_clk) begin
        r_hold   <= n_hold;
        r_skip   <= n_skip;
        r_height <= n_height;
        r_width  <= n_width;
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_fire) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Result payload; sizes are zero on any error
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result.status       <= w_status;
            r_result.is_cmyk      <= w_cmyk;
            r_result.image_width  <= (w_status == ST_OK) ? r_width  : 16'd0;
            r_result.image_height <= (w_status == ST_OK) ? r_height : 16'd0;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule

// ===== rtl/jpeg_sof_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// jpeg_sof_header_parser_top
// JPEG SOF header parser: a byte per cycle unless stalled, one result per file.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one file byte per transfer in s_axis_tdata. tuser marks
//   the first byte of a new file (restarts the parse), tlast marks the end
//   of the file (that transfer's data byte is ignored).
//   Master stream: one result per file: status, width, height, CMYK flag.
//   Results come for a missing start marker, an end or fill marker, a bad
//   component count, an early end, a segment length under two, or a
//   completed frame header; later bytes are dropped until the next tuser.
// Timing:
//   One byte per cycle unless a held result stalls. A byte enters the
//   input register at its transfer and is parsed from there once the
//   result register is free or being read; its result is registered in
//   the result register, which drives tvalid. The input register and
//   the result register decouple the two sides; a stalled master holds
//   the result and back-pressures the slave side only once both
//   registers are full.
// Reset: synchronous, active low; the parser waits for a start marker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jpeg_sof_header_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] first_byte
    input  logic        i_s_axis_tlast,   // end_of_stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [2:0] status, [18:3] image_width,
                                          // [34:19] image_height, [35] is_cmyk,
                                          // [39:36] zero
);
    import jsof_pkg::*;

    t_in_item  w_in_item;
    t_in_stage w_stage;
    logic      w_take;
    t_result   w_result;

    assign w_in_item.data_byte     = i_s_axis_tdata;
    assign w_in_item.first_byte    = i_s_axis_tuser;
    assign w_in_item.end_of_stream = i_s_axis_tlast;

    // Input register
    jsof_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (w_in_item),
        .o_stage (w_stage),
        .i_take  (w_take)
    );

    // Parser and result register
    jsof_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (w_stage),
        .o_take      (w_take),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_result    (w_result)
    );

    // Pack the result, lowest field first
    assign o_m_axis_tdata = {4'd0, w_result.is_cmyk, w_result.image_height,
                             w_result.image_width, w_result.status};

    // Status code stays within the defined set
    `ASSERT_ALWAYS(a_status_range, i_clk, i_rst_n,
        !o_m_axis_tvalid || o_m_axis_tdata[2:0] <= ST_SHORT_LEN)
    // Error results carry no sizes and no CMYK flag
    `ASSERT_ALWAYS(a_error_zero, i_clk, i_rst_n,
        !o_m_axis_tvalid || o_m_axis_tdata[2:0] == ST_OK || o_m_axis_tdata[35:3] == 33'd0)
    // A byte in the input register is never dropped while the parser stalls
    `ASSERT_NEXT(a_hold_byte, i_clk, i_rst_n,
        w_stage.valid && !w_take, w_stage.valid)

endmodule
